// ===== sv/trp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants for the TFTP request parser.
// ----------------------------------------------------------------------------
package trp_pkg;

   localparam int NAME_BUFFER_BYTES_DEFAULT = 256;

   localparam logic [15:0] DEFAULT_BLOCK_SIZE_RESET = 16'd512;
   localparam logic [15:0] MAX_BLOCK_SIZE_RESET     = 16'd512;
   localparam logic [15:0] MIN_BLOCK_SIZE           = 16'd8;
   localparam logic [15:0] POSITION_MAX             = 16'hFFFF;

   localparam logic [15:0] OPCODE_RRQ = 16'd1;
   localparam logic [15:0] OPCODE_WRQ = 16'd2;

   localparam logic [3:0] KEY_LENGTH   = 4'd7;
   localparam logic [3:0] KEY_MISMATCH = 4'd8;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      STATUS_READ     = 2'd0,
      STATUS_WRITE    = 2'd1,
      STATUS_BAD      = 2'd2,
      STATUS_NOT_REQ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FIELD_NAME  = 2'd0,
      FIELD_MODE  = 2'd1,
      FIELD_KEY   = 2'd2,
      FIELD_VALUE = 2'd3
   } field_type;

   typedef enum logic {
      REG_DEFAULT_BLOCK_SIZE = 1'b0,
      REG_MAX_BLOCK_SIZE     = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [15:0] default_block_size;
      logic [15:0] max_block_size;
   } cfg_type;

   // lower-case letters of the option name "blksize"
   function automatic logic [7:0] key_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "b";
         3'd1:    c = "l";
         3'd2:    c = "k";
         3'd3:    c = "s";
         3'd4:    c = "i";
         3'd5:    c = "z";
         3'd6:    c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== sv/trp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_req_if / trp_rsp_if
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface trp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface trp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] opcode;
   logic [15:0] blk_size;
   logic        option_accepted;

   modport source (output valid, output status, output opcode, output blk_size,
                   output option_accepted, input ready);
   modport sink   (input valid, input status, input opcode, input blk_size,
                   input option_accepted, output ready);
endinterface

// ===== sv/tftp_request_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_request_parser
// Byte-serial parser for TFTP read/write requests with the blksize option.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one packet word per handshake (data_byte, last_byte), the
//   opcode high byte first. rsp carries one word per packet, issued after the
//   word flagged last_byte: status, opcode, blk_size, option_accepted.
//   The csr port holds default_block_size (addr 0) and max_block_size (addr 4).
// Timing:
//   one word per clock sustained unless the parse stage stalls (see Stall). A
//   byte is held in the input register, then a single pass of parse logic
//   updates the packet state and, on the last byte, loads the result register
//   that drives rsp.
// Reset:
//   synchronous; clears the pipeline valids and the packet state except opc_ff
//   and chosen_ff; registers return to 512. No clearing pass.
// Stall:
//   a result waiting in the output register holds the parse stage at a last byte;
//   bytes keep flowing until the parse stage meets a last byte with the output still full,
//   then req.ready drops until rsp.ready is seen.
// ----------------------------------------------------------------------------
module tftp_request_parser #(
   parameter int NAME_BUFFER_BYTES = trp_pkg::NAME_BUFFER_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   trp_req_if.sink                             req,
   trp_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [trp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [trp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [trp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   trp_pkg::cfg_type cfg;

   trp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // packet state
   logic [15:0]         pos_ff, pos_in;
   logic [15:0]         opc_ff, opc_in;
   trp_pkg::field_type  field_ff, field_in;
   logic                name_bad_ff, name_bad_in;
   logic                name_dot_ff, name_dot_in;
   logic                name_term_ff, name_term_in;
   logic [3:0]          key_prog_ff, key_prog_in;
   logic                key_match_ff, key_match_in;
   logic [15:0]         val_acc_ff, val_acc_in;
   logic                val_fail_ff, val_fail_in;
   logic                val_nonempty_ff, val_nonempty_in;
   logic [15:0]         chosen_ff, chosen_in;
   logic                opt_seen_ff, opt_seen_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   trp_pkg::status_type out_status_ff, res_status;
   logic [15:0]         out_opcode_ff, res_opcode;
   logic [15:0]         out_bsize_ff, res_bsize;
   logic                out_acc_ff, res_acc;

   logic        advance, fire, done;
   logic [7:0]  b;
   logic        body;
   logic        is_digit;
   logic [3:0]  digit;
   logic [19:0] val_next;
   logic        val_ok;
   logic [16:0] name_span;

   assign b        = in_byte_ff;
   assign advance  = ~out_valid_ff | rsp.ready;
   assign fire     = in_valid_ff & (advance | ~in_last_ff);
   assign done     = fire & in_last_ff;
   assign req.ready = ~in_valid_ff | fire;
   assign body     = (pos_ff != 16'd0) && (pos_ff != 16'd1);

   assign is_digit  = (b >= "0") && (b <= "9");
   assign digit     = 4'(b - "0");
   assign val_next  = {4'h0, val_acc_ff} * 20'd10 + {16'h0000, digit};
   assign val_ok    = key_match_ff && val_nonempty_ff && !val_fail_ff &&
                      (val_acc_ff >= trp_pkg::MIN_BLOCK_SIZE);
   assign name_span = {1'b0, pos_ff} - 17'd2;

   // field sequencing
   always_comb begin
      field_in = field_ff;
      if (body && b == 8'h00) begin
         case (field_ff)
            trp_pkg::FIELD_NAME:  field_in = trp_pkg::FIELD_MODE;
            trp_pkg::FIELD_MODE:  field_in = trp_pkg::FIELD_KEY;
            trp_pkg::FIELD_KEY:   field_in = trp_pkg::FIELD_VALUE;
            trp_pkg::FIELD_VALUE: field_in = trp_pkg::FIELD_KEY;
            default:              field_in = trp_pkg::FIELD_NAME;
         endcase
      end
   end

   // per-field datapath
   always_comb begin
      opc_in          = opc_ff;
      name_bad_in     = name_bad_ff;
      name_dot_in     = name_dot_ff;
      name_term_in    = name_term_ff;
      key_prog_in     = key_prog_ff;
      key_match_in    = key_match_ff;
      val_acc_in      = val_acc_ff;
      val_fail_in     = val_fail_ff;
      val_nonempty_in = val_nonempty_ff;
      chosen_in       = chosen_ff;
      opt_seen_in     = opt_seen_ff;

      if (pos_ff == 16'd0) begin
         opc_in = {b, 8'h00};
      end else if (pos_ff == 16'd1) begin
         opc_in = {opc_ff[15:8], b};
      end else begin
         case (field_ff)
            trp_pkg::FIELD_NAME: begin
               if (b != 8'h00) begin
                  // first name byte sits at position 2
                  if (pos_ff == 16'd2 && (b == "/" || b == "\\")) name_bad_in = 1'b1;
                  if (b == "." && name_dot_ff) name_bad_in = 1'b1;
                  name_dot_in = (b == ".");
               end else begin
                  name_term_in = 1'b1;
                  if (pos_ff == 16'd2) name_bad_in = 1'b1;
                  if (name_span >= 17'(NAME_BUFFER_BYTES)) name_bad_in = 1'b1;
               end
            end
            trp_pkg::FIELD_MODE: begin
               if (b == 8'h00) key_prog_in = 4'd0;
            end
            trp_pkg::FIELD_KEY: begin
               if (b != 8'h00) begin
                  if (key_prog_ff < trp_pkg::KEY_LENGTH &&
                      trp_pkg::lower_ascii(b) == trp_pkg::key_char(key_prog_ff[2:0])) begin
                     key_prog_in = key_prog_ff + 4'd1;
                  end else begin
                     key_prog_in = trp_pkg::KEY_MISMATCH;
                  end
               end else begin
                  key_match_in    = (key_prog_ff == trp_pkg::KEY_LENGTH);
                  val_acc_in      = 16'd0;
                  val_fail_in     = 1'b0;
                  val_nonempty_in = 1'b0;
               end
            end
            trp_pkg::FIELD_VALUE: begin
               if (b != 8'h00) begin
                  val_nonempty_in = 1'b1;
                  if (!is_digit) begin
                     val_fail_in = 1'b1;
                  end else if (!val_fail_ff) begin
                     // overflow keeps the last in-range value
                     if (val_next > 20'd65535) val_fail_in = 1'b1;
                     else val_acc_in = val_next[15:0];
                  end
               end else begin
                  if (val_ok) begin
                     chosen_in   = (val_acc_ff > cfg.max_block_size) ?
                                   cfg.max_block_size : val_acc_ff;
                     opt_seen_in = 1'b1;
                  end
                  key_prog_in  = 4'd0;
                  key_match_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      pos_in = (pos_ff == trp_pkg::POSITION_MAX) ? pos_ff : pos_ff + 16'd1;
   end

   // result from the state after this byte
   always_comb begin
      res_opcode = (pos_in >= 16'd2) ? opc_in : 16'd0;
      res_bsize  = cfg.default_block_size;
      res_acc    = 1'b0;
      if (pos_in < 16'd2 ||
          (res_opcode != trp_pkg::OPCODE_RRQ && res_opcode != trp_pkg::OPCODE_WRQ)) begin
         res_status = trp_pkg::STATUS_NOT_REQ;
      end else if (!name_term_in || name_bad_in) begin
         res_status = trp_pkg::STATUS_BAD;
      end else begin
         res_status = (res_opcode == trp_pkg::OPCODE_RRQ) ?
                      trp_pkg::STATUS_READ : trp_pkg::STATUS_WRITE;
         if (opt_seen_in) begin
            res_bsize = chosen_in;
            res_acc   = 1'b1;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (done) out_valid_in = 1'b1;
      else if (rsp.ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pos_ff          <= 16'd0;
         field_ff        <= trp_pkg::FIELD_NAME;
         name_bad_ff     <= 1'b0;
         name_dot_ff     <= 1'b0;
         name_term_ff    <= 1'b0;
         key_prog_ff     <= 4'd0;
         key_match_ff    <= 1'b0;
         val_acc_ff      <= 16'd0;
         val_fail_ff     <= 1'b0;
         val_nonempty_ff <= 1'b0;
         opt_seen_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (done) begin
            pos_ff          <= 16'd0;
            field_ff        <= trp_pkg::FIELD_NAME;
            name_bad_ff     <= 1'b0;
            name_dot_ff     <= 1'b0;
            name_term_ff    <= 1'b0;
            key_prog_ff     <= 4'd0;
            key_match_ff    <= 1'b0;
            val_acc_ff      <= 16'd0;
            val_fail_ff     <= 1'b0;
            val_nonempty_ff <= 1'b0;
            opt_seen_ff     <= 1'b0;
         end else if (fire) begin
            pos_ff          <= pos_in;
            field_ff        <= field_in;
            name_bad_ff     <= name_bad_in;
            name_dot_ff     <= name_dot_in;
            name_term_ff    <= name_term_in;
            key_prog_ff     <= key_prog_in;
            key_match_ff    <= key_match_in;
            val_acc_ff      <= val_acc_in;
            val_fail_ff     <= val_fail_in;
            val_nonempty_ff <= val_nonempty_in;
            opt_seen_ff     <= opt_seen_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
      if (fire) begin
         opc_ff    <= opc_in;
         chosen_ff <= chosen_in;
      end
      if (done) begin
         out_status_ff <= res_status;
         out_opcode_ff <= res_opcode;
         out_bsize_ff  <= res_bsize;
         out_acc_ff    <= res_acc;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.status          = out_status_ff;
   assign rsp.opcode          = out_opcode_ff;
   assign rsp.blk_size        = out_bsize_ff;
   assign rsp.option_accepted = out_acc_ff;

endmodule

// ===== sv/trp_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_csr
// APB-style register file holding the default and maximum block size.
// ----------------------------------------------------------------------------
module trp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [trp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [trp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [trp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output trp_pkg::cfg_type                    cfg
);

   logic [15:0] default_ff, default_in;
   logic [15:0] max_ff, max_in;
   logic        wr_en;
   trp_pkg::reg_index_type idx;

   // registers are word aligned, low address bits ignored
   assign idx        = trp_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      default_in = default_ff;
      max_in     = max_ff;
      if (wr_en) begin
         case (idx)
            trp_pkg::REG_DEFAULT_BLOCK_SIZE: default_in = csr_pwdata[15:0];
            trp_pkg::REG_MAX_BLOCK_SIZE:     max_in     = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         trp_pkg::REG_DEFAULT_BLOCK_SIZE: csr_prdata = {16'h0000, default_ff};
         trp_pkg::REG_MAX_BLOCK_SIZE:     csr_prdata = {16'h0000, max_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= trp_pkg::DEFAULT_BLOCK_SIZE_RESET;
         max_ff     <= trp_pkg::MAX_BLOCK_SIZE_RESET;
      end else begin
         default_ff <= default_in;
         max_ff     <= max_in;
      end
   end

   assign cfg.default_block_size = default_ff;
   assign cfg.max_block_size     = max_ff;

endmodule

// ===== bench/tftp_request_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_request_parser_tb
// Self-checking bench for the TFTP request parser. Packets are sent one byte
// per word on req while a behavioral parser tracks the same packet state and
// queues the verdict that each last byte should produce. Every verdict word
// on rsp is compared field by field with the oldest queued one. Directed
// packets cover short and foreign packets, filename rules, the blksize
// option and the block size registers; random packets then run under
// several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tftp_request_parser_tb;

   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          MAX_SEND_GAP  = 40;
   localparam int          RANDOM_WORDS  = 600;
   localparam int          RANDOM_PHASES = 8;
   localparam logic [55:0] OPTION_KEY    = "blksize";

   typedef struct {
      trp_pkg::status_type status;
      logic [15:0]         opcode;
      logic [15:0]         blk_size;
      logic                option_accepted;
   } request_verdict_type;

   logic clock = 1'b0;
   logic reset;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [trp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [trp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [trp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   trp_req_if req_if ();
   trp_rsp_if rsp_if ();

   tftp_request_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // behavioral copy of the parser state and registers
   trp_pkg::cfg_type   block_limits;
   logic [15:0]        byte_pos;
   logic [15:0]        opcode_bytes;
   trp_pkg::field_type field;
   logic [8:0]         name_len;
   logic               name_bad;
   logic               prev_dot;
   logic               name_done;
   logic [3:0]         key_prog;
   logic               key_hit;
   logic [16:0]        value_acc;
   logic               value_fail;
   logic               value_nonempty;
   logic [15:0]        chosen_size;
   logic               option_seen;

   request_verdict_type request_verdicts[$];
   logic [7:0]          packet_bytes[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int verdicts_seen  = 0;
   int words_sent     = 0;
   int settings_used  = 0;
   int cycle_count    = 0;

   function automatic void clear_packet_state();
      byte_pos       = '0;
      opcode_bytes   = '0;
      field          = trp_pkg::FIELD_NAME;
      name_len       = '0;
      name_bad       = 1'b0;
      prev_dot       = 1'b0;
      name_done      = 1'b0;
      key_prog       = '0;
      key_hit        = 1'b0;
      value_acc      = '0;
      value_fail     = 1'b0;
      value_nonempty = 1'b0;
      chosen_size    = block_limits.default_block_size;
      option_seen    = 1'b0;
   endfunction

   task automatic parse_request_byte(input logic [7:0] b, input logic last);
      logic [15:0]         pos;
      logic [7:0]          lc;
      int unsigned         grown;
      request_verdict_type verdict;
      pos = byte_pos;
      if (pos == 16'd0) begin
         opcode_bytes = {b, 8'h00};
      end else if (pos == 16'd1) begin
         opcode_bytes[7:0] = b;
      end else begin
         case (field)
            trp_pkg::FIELD_NAME: begin
               if (b != 8'h00) begin
                  if (name_len == 9'd0 && (b == "/" || b == "\\")) name_bad = 1'b1;
                  if (b == "." && prev_dot) name_bad = 1'b1;
                  prev_dot = (b == ".");
                  if (name_len != 9'd511) name_len = name_len + 9'd1;
               end else begin
                  name_done = 1'b1;
                  if (name_len == 9'd0) name_bad = 1'b1;
                  if (int'(pos) - 2 >= trp_pkg::NAME_BUFFER_BYTES_DEFAULT) name_bad = 1'b1;
                  field = trp_pkg::FIELD_MODE;
               end
            end
            trp_pkg::FIELD_MODE: begin
               if (b == 8'h00) begin
                  field    = trp_pkg::FIELD_KEY;
                  key_prog = '0;
               end
            end
            trp_pkg::FIELD_KEY: begin
               if (b != 8'h00) begin
                  lc = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
                  if (key_prog < trp_pkg::KEY_LENGTH &&
                      lc == OPTION_KEY[8 * (6 - int'(key_prog)) +: 8]) begin
                     key_prog = key_prog + 4'd1;
                  end else begin
                     key_prog = trp_pkg::KEY_MISMATCH;
                  end
               end else begin
                  key_hit        = (key_prog == trp_pkg::KEY_LENGTH);
                  field          = trp_pkg::FIELD_VALUE;
                  value_acc      = '0;
                  value_fail     = 1'b0;
                  value_nonempty = 1'b0;
               end
            end
            default: begin
               if (b != 8'h00) begin
                  value_nonempty = 1'b1;
                  if (b < "0" || b > "9") begin
                     value_fail = 1'b1;
                  end else if (!value_fail) begin
                     grown = 32'(value_acc) * 10 + 32'(b - "0");
                     if (grown > 32'd65535) value_fail = 1'b1;
                     else value_acc = grown[16:0];
                  end
               end else begin
                  if (key_hit && value_nonempty && !value_fail &&
                      value_acc >= 17'(trp_pkg::MIN_BLOCK_SIZE)) begin
                     chosen_size = (value_acc > 17'(block_limits.max_block_size)) ?
                                   block_limits.max_block_size : value_acc[15:0];
                     option_seen = 1'b1;
                  end
                  field    = trp_pkg::FIELD_KEY;
                  key_prog = '0;
                  key_hit  = 1'b0;
               end
            end
         endcase
      end
      if (byte_pos != trp_pkg::POSITION_MAX) byte_pos = byte_pos + 16'd1;
      if (last) begin
         verdict.opcode          = (byte_pos >= 16'd2) ? opcode_bytes : 16'd0;
         verdict.blk_size        = block_limits.default_block_size;
         verdict.option_accepted = 1'b0;
         if (byte_pos < 16'd2 || (verdict.opcode != trp_pkg::OPCODE_RRQ &&
                                  verdict.opcode != trp_pkg::OPCODE_WRQ)) begin
            verdict.status = trp_pkg::STATUS_NOT_REQ;
         end else if (!name_done || name_bad) begin
            verdict.status = trp_pkg::STATUS_BAD;
         end else begin
            verdict.status = (verdict.opcode == trp_pkg::OPCODE_RRQ) ?
                             trp_pkg::STATUS_READ : trp_pkg::STATUS_WRITE;
            if (option_seen) begin
               verdict.blk_size        = chosen_size;
               verdict.option_accepted = 1'b1;
            end
         end
         request_verdicts.push_back(verdict);
         clear_packet_state();
      end
   endtask

   // follow every accepted packet byte
   always @(posedge clock) begin
      if (reset) begin
         block_limits.default_block_size = trp_pkg::DEFAULT_BLOCK_SIZE_RESET;
         block_limits.max_block_size     = trp_pkg::MAX_BLOCK_SIZE_RESET;
         clear_packet_state();
      end else if (req_if.valid && req_if.ready) begin
         parse_request_byte(req_if.data_byte, req_if.last_byte);
      end
   end

   // compare each verdict word with the oldest prediction
   always @(posedge clock) begin
      request_verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         verdicts_seen++;
         if (request_verdicts.size() == 0) begin
            $error("verdict word with no packet pending: status %0d opcode %0h",
                   rsp_if.status, rsp_if.opcode);
            mismatch_count++;
         end else begin
            want = request_verdicts.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.opcode !== want.opcode) begin
               $error("opcode: expected %0h, got %0h", want.opcode, rsp_if.opcode);
               mismatch_count++;
            end
            if (rsp_if.blk_size !== want.blk_size) begin
               $error("blk_size: expected %0d, got %0d", want.blk_size, rsp_if.blk_size);
               mismatch_count++;
            end
            if (rsp_if.option_accepted !== want.option_accepted) begin
               $error("option_accepted: expected %0d, got %0d", want.option_accepted,
                      rsp_if.option_accepted);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                  request_verdicts.size());
         $display("tftp_request_parser regression: fail");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++) begin
         send_word(packet_bytes[i], i == packet_bytes.size() - 1);
      end
      packet_bytes.delete();
   endtask

   // drop valid and let the last verdict drain before touching registers
   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (request_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input trp_pkg::reg_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == trp_pkg::REG_DEFAULT_BLOCK_SIZE) block_limits.default_block_size = value;
      else block_limits.max_block_size = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_block_limits(input logic [15:0] dflt, input logic [15:0] limit);
      wait_for_idle();
      csr_write(trp_pkg::REG_DEFAULT_BLOCK_SIZE, dflt);
      csr_write(trp_pkg::REG_MAX_BLOCK_SIZE, limit);
      settings_used++;
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) packet_bytes.push_back(s[i]);
   endfunction

   function automatic void push_field(input string s);
      push_text(s);
      packet_bytes.push_back(8'h00);
   endfunction

   function automatic void push_repeat(input logic [7:0] c, input int n);
      for (int i = 0; i < n; i++) packet_bytes.push_back(c);
   endfunction

   // opcode bytes go straight to the queue, a string would drop the zero byte
   function automatic void push_opcode(input logic [15:0] op);
      packet_bytes.push_back(op[15:8]);
      packet_bytes.push_back(op[7:0]);
   endfunction

   function automatic void push_head(input logic [15:0] op, input string name);
      push_opcode(op);
      push_field(name);
      push_field("octet");
   endfunction

   task automatic test_short_and_foreign_packets();
      packet_bytes.push_back(8'h00);
      send_packet();
      packet_bytes.push_back(8'hFF);
      send_packet();
      // opcode only, name never starts
      push_opcode(trp_pkg::OPCODE_RRQ);
      send_packet();
      push_head(16'h0000, "file");
      send_packet();
      push_head(16'h0003, "file");
      send_packet();
      push_head(16'hFFFF, "file");
      send_packet();
      push_head(16'h0100, "file");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "file.txt");
      send_packet();
      push_head(trp_pkg::OPCODE_WRQ, "file.txt");
      send_packet();
   endtask

   task automatic test_filename_rules();
      push_head(trp_pkg::OPCODE_RRQ, "");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "/etc");
      send_packet();
      push_head(trp_pkg::OPCODE_WRQ, "\\boot");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "a..b");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "a.b.c/d\\e");
      send_packet();
      // name still open at the last byte
      push_opcode(trp_pkg::OPCODE_RRQ);
      push_text("abc");
      send_packet();
      // longest accepted name, then one byte too long
      push_opcode(trp_pkg::OPCODE_RRQ);
      push_repeat("n", 255);
      push_field("");
      push_field("octet");
      send_packet();
      push_opcode(trp_pkg::OPCODE_WRQ);
      push_repeat("n", 256);
      push_field("");
      push_field("octet");
      send_packet();
   endtask

   task automatic test_blksize_option();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("8");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("7");
      send_packet();
      push_head(trp_pkg::OPCODE_WRQ, "f");
      push_field("blksize");
      push_field("65535");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("65536");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("6553699");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("BlKsIzE");
      push_field("0000000000016");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("");
      push_field("blksize");
      push_field("1a4");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksiz");
      push_field("100");
      push_field("blksizee");
      push_field("100");
      send_packet();
      // later valid pair wins, later bad pair is dropped
      push_head(trp_pkg::OPCODE_WRQ, "f");
      push_field("blksize");
      push_field("100");
      push_field("blksize");
      push_field("200");
      push_field("blksize");
      push_field("5");
      send_packet();
      // value still open at the last byte
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_text("300");
      send_packet();
      push_opcode(trp_pkg::OPCODE_RRQ);
      push_field("f");
      push_text("octet");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("timeout");
      push_field("5");
      push_field("blksize");
      push_field("1428");
      send_packet();
   endtask

   task automatic test_block_limits();
      apply_block_limits(16'd1, trp_pkg::MIN_BLOCK_SIZE);
      push_head(trp_pkg::OPCODE_RRQ, "f");
      send_packet();
      push_head(trp_pkg::OPCODE_RRQ, "f");
      push_field("blksize");
      push_field("100");
      send_packet();
      push_head(trp_pkg::OPCODE_WRQ, "..");
      push_field("blksize");
      push_field("8");
      send_packet();
      apply_block_limits(16'hFFFF, 16'hFFFF);
      push_head(trp_pkg::OPCODE_RRQ, "f");
      send_packet();
      push_head(trp_pkg::OPCODE_WRQ, "f");
      push_field("blksize");
      push_field("65535");
      send_packet();
      apply_block_limits(trp_pkg::DEFAULT_BLOCK_SIZE_RESET, trp_pkg::MAX_BLOCK_SIZE_RESET);
   endtask

   function automatic void push_random_option();
      int    pick;
      int    n;
      string key;
      pick = $urandom_range(99);
      key  = (pick < 80) ? "blksize" : ((pick < 90) ? "blksiz" : "blksizex");
      if (pick < 60) begin
         for (int i = 0; i < key.len(); i++) begin
            packet_bytes.push_back($urandom_range(1) ? key[i] - 8'h20 : key[i]);
         end
         packet_bytes.push_back(8'h00);
      end else if (pick < 80) begin
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) packet_bytes.push_back(8'($urandom_range(255, 1)));
         packet_bytes.push_back(8'h00);
      end else begin
         push_field(key);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
         push_field($sformatf("%0d", $urandom_range(2000, 8)));
      end else if (pick < 55) begin
         push_field($sformatf("%0d", $urandom_range(65535, 8)));
      end else if (pick < 65) begin
         push_field($sformatf("%0d", $urandom_range(7)));
      end else if (pick < 75) begin
         push_field($sformatf("%0d", $urandom_range(999999, 65536)));
      end else if (pick < 85) begin
         n = int'(block_limits.max_block_size) + $urandom_range(4) - 2;
         push_field($sformatf("%0d", (n < 0) ? 0 : ((n > 65535) ? 65535 : n)));
      end else if (pick < 90) begin
         push_repeat("0", $urandom_range(5, 1));
         push_field($sformatf("%0d", $urandom_range(9999)));
      end else if (pick < 95) begin
         push_text($sformatf("%0d", $urandom_range(999)));
         packet_bytes.push_back(8'($urandom_range(255, 1)));
         push_field($sformatf("%0d", $urandom_range(99)));
      end else begin
         push_field("");
      end
   endfunction

   function automatic void build_random_packet();
      int          pick;
      int          n;
      int          cut;
      logic [15:0] op;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick >= 80) begin
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++) packet_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      pick = $urandom_range(99);
      op = (pick < 45) ? trp_pkg::OPCODE_RRQ :
           ((pick < 85) ? trp_pkg::OPCODE_WRQ : 16'($urandom));
      push_opcode(op);
      pick = $urandom_range(99);
      n = (pick < 3) ? $urandom_range(258, 252) : ((pick < 8) ? 0 : $urandom_range(8, 1));
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) c = ".";
         else if (pick < 19) c = "/";
         else if (pick < 23) c = "\\";
         else if (pick < 33) c = 8'($urandom_range(255, 1));
         else c = 8'("a" + $urandom_range(25));
         packet_bytes.push_back(c);
      end
      packet_bytes.push_back(8'h00);
      pick = $urandom_range(2);
      push_field((pick == 0) ? "octet" : ((pick == 1) ? "netascii" : "mail"));
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) push_random_option();
      // some packets are cut short anywhere
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(packet_bytes.size(), 1);
         while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
      end
   endfunction

   task automatic test_random_traffic();
      int          goal;
      logic [15:0] dflt;
      logic [15:0] limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin dflt = 16'd512;   limit = 16'd512;   end
            1: begin dflt = 16'd1;     limit = 16'd8;     end
            2: begin dflt = 16'hFFFF;  limit = 16'hFFFF;  end
            3: begin dflt = 16'd1000;  limit = 16'd1400;  end
            4: begin dflt = 16'd8;     limit = 16'hFFFF;  end
            5: begin dflt = 16'hFFFF;  limit = 16'd8;     end
            default: begin
               dflt  = 16'($urandom_range(65535, 1));
               limit = 16'($urandom_range(65535, 8));
            end
         endcase
         apply_block_limits(dflt, limit);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         goal = words_sent + RANDOM_WORDS / RANDOM_PHASES;
         while (words_sent < goal) begin
            build_random_packet();
            send_packet();
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.last_byte <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_and_foreign_packets();
      test_filename_rules();
      test_blksize_option();
      test_block_limits();
      test_random_traffic();

      wait_for_idle();
      repeat (8) @(posedge clock);
      if (request_verdicts.size() != 0) begin
         $error("%0d predicted verdicts never arrived", request_verdicts.size());
         mismatch_count++;
      end
      $display("checked %0d verdict words from %0d packet bytes", verdicts_seen, words_sent);
      $display("covered %0d block size settings with idle and stall mixes, %0d mismatches",
               settings_used, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tftp_request_parser regression: pass");
      end else begin
         $display("tftp_request_parser regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/trp_pkg.sv
sv/trp_if.sv
sv/trp_csr.sv
sv/tftp_request_parser.sv
bench/tftp_request_parser_tb.sv
